// ===== src/sp256_pkg.sv =====
// Serpent-256 package: S-box tables, linear transform functions, command codes.
// Depends on nothing; used by all modules of the block.
package sp256_pkg;

  localparam int unsigned SubkeyWords = 132;
  localparam int unsigned SubkeyAddrW = 8;
  localparam int unsigned RegIdxW = 3;
  localparam logic [31:0] Phi = 32'h9E3779B9;

  typedef enum logic [1:0] {
    CMD_ENC = 2'd0,
    CMD_DEC = 2'd1,
    CMD_CTR = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  typedef enum logic [RegIdxW-1:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3,
    REG_IVH  = 3'd4,
    REG_IVL  = 3'd5
  } reg_idx_t;

  typedef logic [3:0][31:0] blk_t;

  // Request from control to the subkey store.
  typedef struct packed {
    logic                   we;
    logic [SubkeyAddrW-1:0] waddr;
    logic [31:0]            wdata;
    logic [SubkeyAddrW-3:0] raddr;
  } sk_req_t;

  function automatic logic [3:0] sbox_lookup_fwd(input logic [2:0] which,
                                                 input logic [3:0] n);
    logic [3:0] f;
    f = 4'd0;
    case (which)
      3'd0: case (n)
        4'd0: f=4'd3;  4'd1: f=4'd8;  4'd2: f=4'd15; 4'd3: f=4'd1;
        4'd4: f=4'd10; 4'd5: f=4'd6;  4'd6: f=4'd5;  4'd7: f=4'd11;
        4'd8: f=4'd14; 4'd9: f=4'd13; 4'd10: f=4'd4; 4'd11: f=4'd2;
        4'd12: f=4'd7; 4'd13: f=4'd0; 4'd14: f=4'd9; default: f=4'd12;
      endcase
      3'd1: case (n)
        4'd0: f=4'd15; 4'd1: f=4'd12; 4'd2: f=4'd2;  4'd3: f=4'd7;
        4'd4: f=4'd9;  4'd5: f=4'd0;  4'd6: f=4'd5;  4'd7: f=4'd10;
        4'd8: f=4'd1;  4'd9: f=4'd11; 4'd10: f=4'd14; 4'd11: f=4'd8;
        4'd12: f=4'd6; 4'd13: f=4'd13; 4'd14: f=4'd3; default: f=4'd4;
      endcase
      3'd2: case (n)
        4'd0: f=4'd8;  4'd1: f=4'd6;  4'd2: f=4'd7;  4'd3: f=4'd9;
        4'd4: f=4'd3;  4'd5: f=4'd12; 4'd6: f=4'd10; 4'd7: f=4'd15;
        4'd8: f=4'd13; 4'd9: f=4'd1;  4'd10: f=4'd14; 4'd11: f=4'd4;
        4'd12: f=4'd0; 4'd13: f=4'd11; 4'd14: f=4'd5; default: f=4'd2;
      endcase
      3'd3: case (n)
        4'd0: f=4'd0;  4'd1: f=4'd15; 4'd2: f=4'd11; 4'd3: f=4'd8;
        4'd4: f=4'd12; 4'd5: f=4'd9;  4'd6: f=4'd6;  4'd7: f=4'd3;
        4'd8: f=4'd13; 4'd9: f=4'd1;  4'd10: f=4'd2; 4'd11: f=4'd4;
        4'd12: f=4'd10; 4'd13: f=4'd7; 4'd14: f=4'd5; default: f=4'd14;
      endcase
      3'd4: case (n)
        4'd0: f=4'd1;  4'd1: f=4'd15; 4'd2: f=4'd8;  4'd3: f=4'd3;
        4'd4: f=4'd12; 4'd5: f=4'd0;  4'd6: f=4'd11; 4'd7: f=4'd6;
        4'd8: f=4'd2;  4'd9: f=4'd5;  4'd10: f=4'd4; 4'd11: f=4'd10;
        4'd12: f=4'd9; 4'd13: f=4'd14; 4'd14: f=4'd7; default: f=4'd13;
      endcase
      3'd5: case (n)
        4'd0: f=4'd15; 4'd1: f=4'd5;  4'd2: f=4'd2;  4'd3: f=4'd11;
        4'd4: f=4'd4;  4'd5: f=4'd10; 4'd6: f=4'd9;  4'd7: f=4'd12;
        4'd8: f=4'd0;  4'd9: f=4'd3;  4'd10: f=4'd14; 4'd11: f=4'd8;
        4'd12: f=4'd13; 4'd13: f=4'd6; 4'd14: f=4'd7; default: f=4'd1;
      endcase
      3'd6: case (n)
        4'd0: f=4'd7;  4'd1: f=4'd2;  4'd2: f=4'd12; 4'd3: f=4'd5;
        4'd4: f=4'd8;  4'd5: f=4'd4;  4'd6: f=4'd6;  4'd7: f=4'd11;
        4'd8: f=4'd14; 4'd9: f=4'd9;  4'd10: f=4'd1; 4'd11: f=4'd15;
        4'd12: f=4'd13; 4'd13: f=4'd3; 4'd14: f=4'd10; default: f=4'd0;
      endcase
      default: case (n)
        4'd0: f=4'd1;  4'd1: f=4'd13; 4'd2: f=4'd15; 4'd3: f=4'd0;
        4'd4: f=4'd14; 4'd5: f=4'd8;  4'd6: f=4'd2;  4'd7: f=4'd11;
        4'd8: f=4'd7;  4'd9: f=4'd4;  4'd10: f=4'd12; 4'd11: f=4'd10;
        4'd12: f=4'd9; 4'd13: f=4'd3; 4'd14: f=4'd5; default: f=4'd6;
      endcase
    endcase
    return f;
  endfunction

  function automatic logic [3:0] sbox_lookup(input logic [2:0] which, input logic inv,
                                             input logic [3:0] n);
    logic [3:0] r;
    r = 4'd0;
    if (inv) begin
      // inverse: search the forward table for n
      for (int k = 0; k < 16; k++) begin
        if (sbox_lookup_fwd(which, 4'(k)) == n) r = 4'(k);
      end
    end else begin
      r = sbox_lookup_fwd(which, n);
    end
    return r;
  endfunction

  // Bitsliced S-box over four words; nibble i is bit i of words 0..3.
  function automatic blk_t sbox_words(input logic [2:0] which, input logic inv, input blk_t v);
    blk_t o;
    logic [3:0] n;
    logic [3:0] r;
    o = '0;
    for (int i = 0; i < 32; i++) begin
      n = {v[3][i], v[2][i], v[1][i], v[0][i]};
      r = sbox_lookup(which, inv, n);
      o[0][i] = r[0];
      o[1][i] = r[1];
      o[2][i] = r[2];
      o[3][i] = r[3];
    end
    return o;
  endfunction

  function automatic logic [31:0] rol(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic blk_t lin_fwd(input blk_t xi);
    blk_t x;
    x = xi;
    x[0] = rol(x[0], 13);
    x[2] = rol(x[2], 3);
    x[1] = x[1] ^ x[0] ^ x[2];
    x[3] = x[3] ^ x[2] ^ (x[0] << 3);
    x[1] = rol(x[1], 1);
    x[3] = rol(x[3], 7);
    x[0] = x[0] ^ x[1] ^ x[3];
    x[2] = x[2] ^ x[3] ^ (x[1] << 7);
    x[0] = rol(x[0], 5);
    x[2] = rol(x[2], 22);
    return x;
  endfunction

  function automatic blk_t lin_inv(input blk_t xi);
    blk_t x;
    x = xi;
    x[2] = ror(x[2], 22);
    x[0] = ror(x[0], 5);
    x[2] = x[2] ^ x[3] ^ (x[1] << 7);
    x[0] = x[0] ^ x[1] ^ x[3];
    x[3] = ror(x[3], 7);
    x[1] = ror(x[1], 1);
    x[3] = x[3] ^ x[2] ^ (x[0] << 3);
    x[1] = x[1] ^ x[0] ^ x[2];
    x[2] = ror(x[2], 3);
    x[0] = ror(x[0], 13);
    return x;
  endfunction

  function automatic logic [63:0] lead_mask(input logic [4:0] nbytes);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (nbytes > 5'(b)) m[63-8*b -: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

// ===== src/serpent256_block_cipher_ctr.sv =====
// Serpent-256 block cipher with ECB encrypt/decrypt and CTR chunk mode.
// Depends on sp256_pkg, sp256_subkey_ram and sp256_round.
//
// After reset or any key register write the first item triggers key expansion:
// 132 prekey words are computed one per cycle and written into the subkey RAM,
// with the S-box applied to each row of four as it closes.
// A block then runs one round per cycle using one 128-bit subkey row read from
// the single-port-read subkey RAM. An item goes through a RAM prefetch, 33
// round steps (32 rounds plus the final key mix) and a publish state; when
// keys must be expanded, the expansion pass and the wait until the last row
// is written come before the prefetch. One item is in flight at a time. The
// result sits in an output register; the next item is accepted as soon as the
// output register is free or being taken in the same cycle. Configuration
// writes are taken at any time but must only be issued while idle.
module serpent256_block_cipher_ctr
  import sp256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [63:0] data_high,
  input  logic [63:0] data_low,
  input  logic        ctr_start,
  input  logic [4:0]  chunk_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_high,
  output logic [63:0] result_low
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXP   = 5'b00010,
    ST_PRE   = 5'b00100,
    ST_RUN   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [63:0] key [4];
  logic [63:0] iv_h, iv_l;
  logic [127:0] counter;
  logic subkeys_valid;

  // latched item
  cmd_t cmd;
  logic [63:0] dh, dl;
  logic [4:0] nbytes;

  blk_t x;
  logic [5:0] rnd;
  logic [7:0] exp_i;
  logic [31:0] w [8];        // sliding window of prekey words
  blk_t grp;                 // raw prekey row being collected

  sk_req_t req;
  blk_t subkey;
  blk_t y_enc, y_dec, y_mix;

  logic out_free;
  logic take;
  logic [31:0] pk;
  logic [31:0] pk_pre;
  logic [5:0] row_i;
  blk_t grp_full;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && out_free;
  assign take = in_valid && in_ready;

  // prekey recurrence over window w[0..7] = w[i..i+7]
  assign pk_pre = w[0] ^ w[3] ^ w[5] ^ w[7] ^ Phi ^ {24'd0, exp_i};
  assign pk = rol(pk_pre, 11);
  assign row_i = exp_i[7:2];
  always_comb begin
    grp_full = grp;
    grp_full[exp_i[1:0]] = pk;
  end

  // RAM request: S-boxing a row needs the whole row, so a row is captured when
  // its fourth word is computed and then written word by word, word 3 last.
  // The S-box is applied to the whole row below, before any word is written.
  blk_t row_sb;
  assign row_sb = sbox_words(3'(3 - row_i), 1'b0, grp_full);

  logic [1:0] wr_word;
  logic wr_pending;
  blk_t wr_row;
  logic [5:0] wr_row_i;

  // a new row closes in the cycle the previous one writes its last word
  logic row_close;
  assign row_close = (state == ST_EXP) && (exp_i[1:0] == 2'd3);

  always_comb begin
    req = '0;
    if (wr_pending) begin
      req.we = 1'b1;
      req.waddr = {wr_row_i, wr_word};
      req.wdata = wr_row[wr_word];
    end
    // read address: row needed next cycle
    if (state == ST_PRE) begin
      req.raddr = (cmd == CMD_DEC) ? 6'd32 : 6'd0;
    end else if (state == ST_RUN) begin
      if (cmd == CMD_DEC) req.raddr = (rnd == 6'd0) ? 6'd31 : 6'(31 - rnd);
      else req.raddr = (rnd == 6'd31) ? 6'd32 : 6'(rnd + 6'd1);
    end else begin
      req.raddr = '0;
    end
  end

  sp256_subkey_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (subkey)
  );

  // decrypt: step 0 is the final-key mix, step k runs round 32 - k
  logic [5:0] rsel;
  assign rsel = (cmd == CMD_DEC) ? 6'(32 - rnd) : rnd;

  sp256_round u_round (
    .x       (x),
    .subkey  (subkey),
    .decrypt (cmd == CMD_DEC),
    .rnd     (rsel),
    .y_enc   (y_enc),
    .y_dec   (y_dec),
    .y_mix   (y_mix)
  );

  logic last;
  assign last = (rnd == 6'd32);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (take) state_next = subkeys_valid ? ST_PRE : ST_EXP;
      ST_EXP:  if (exp_i == 8'(SubkeyWords - 1)) state_next = ST_PRE;
      // hold the prefetch until the last expanded row is fully written
      ST_PRE:  if (!wr_pending) state_next = ST_RUN;
      ST_RUN:  if (last) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  logic is_ctr_go;
  assign is_ctr_go = (cmd == CMD_CTR) && (nbytes != 5'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      subkeys_valid <= 1'b0;
      counter <= '0;
      out_valid <= 1'b0;
      wr_pending <= 1'b0;
      for (int k = 0; k < 4; k++) key[k] <= '0;
      iv_h <= '0;
      iv_l <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
            key[cfg_index[1:0]] <= cfg_data;
            subkeys_valid <= 1'b0;
          end
          REG_IVH: iv_h <= cfg_data;
          REG_IVL: iv_l <= cfg_data;
          default: ;
        endcase
      end

      // drain a finished row, one word per cycle (done by the time the next row closes)
      if (wr_pending && !row_close) begin
        wr_word <= wr_word + 2'd1;
        if (wr_word == 2'd3) wr_pending <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (take) begin
            cmd <= cmd_t'(command);
            dh <= data_high;
            dl <= data_low;
            nbytes <= (chunk_bytes > 5'd16) ? 5'd16 : chunk_bytes;
            if (cmd_t'(command) == CMD_CTR && ctr_start) counter <= {iv_h, iv_l};
            exp_i <= '0;
            for (int k = 0; k < 4; k++) begin
              w[2*k]   <= key[k][63:32];
              w[2*k+1] <= key[k][31:0];
            end
          end
        end
        ST_EXP: begin
          for (int k = 0; k < 7; k++) w[k] <= w[k+1];
          w[7] <= pk;
          grp <= grp_full;
          exp_i <= exp_i + 8'd1;
          if (row_close) begin
            wr_pending <= 1'b1;
            wr_word <= 2'd0;
            wr_row <= row_sb;
            wr_row_i <= row_i;
          end
          if (exp_i == 8'(SubkeyWords - 1)) subkeys_valid <= 1'b1;
        end
        ST_PRE: begin
          rnd <= '0;
          if (cmd == CMD_CTR) begin
            x <= {counter[31:0], counter[63:32], counter[95:64], counter[127:96]};
          end else begin
            x <= {dl[31:0], dl[63:32], dh[31:0], dh[63:32]};
          end
        end
        ST_RUN: begin
          rnd <= rnd + 6'd1;
          if (cmd == CMD_DEC) x <= (rnd == 6'd0) ? y_mix : y_dec;
          else if (last) x <= y_mix;
          else x <= y_enc;
        end
        ST_DONE: begin
          out_valid <= 1'b1;
          case (cmd)
            CMD_ENC, CMD_DEC: begin
              result_high <= {x[0], x[1]};
              result_low  <= {x[2], x[3]};
            end
            CMD_CTR: begin
              result_high <= (dh ^ {x[0], x[1]}) & lead_mask(nbytes);
              result_low  <= (dl ^ {x[2], x[3]}) &
                             lead_mask((nbytes > 5'd8) ? 5'(nbytes - 5'd8) : 5'd0);
              if (is_ctr_go) counter <= counter + 128'd1;
            end
            default: begin
              result_high <= '0;
              result_low  <= '0;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // the x register is word-indexed with word 0 at the top of the counter
  // (counter[127:96] is word 0); blk_t packs word 3 in the high bits, so the
  // loads above place word 0 at index 0.

  // no new transfer while an item is in flight
  assert property (@(posedge clk) disable iff (rst) take |=> !in_ready)
    else $error("input taken while busy");

  // a result appears only after the publish state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result without completed item");

  // rounds only run on expanded subkeys
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> subkeys_valid)
    else $error("rounds on stale subkeys");

endmodule

// ===== src/sp256_subkey_ram.sv =====
// Subkey store: 33 rows of 128 bits, written one word at a time, read by row.
// Depends on sp256_pkg for request type and sizes.
module sp256_subkey_ram
  import sp256_pkg::*;
(
  input  logic    clk,
  input  sk_req_t req,
  output blk_t    rdata
);

  localparam int unsigned Rows = SubkeyWords / 4;

  blk_t mem [Rows];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[SubkeyAddrW-1:2]][req.waddr[1:0]] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== src/sp256_round.sv =====
// One Serpent round step (key mix, S-box, linear transform) for either direction.
// Depends on sp256_pkg for S-box and linear transform functions.
module sp256_round
  import sp256_pkg::*;
(
  input  blk_t       x,
  input  blk_t       subkey,
  input  logic       decrypt,
  input  logic [5:0] rnd,
  output blk_t       y_enc,
  output blk_t       y_dec,
  output blk_t       y_mix
);

  blk_t mixed;
  blk_t lin;

  // encrypt: mix, S-box, then linear step (round 31 skips it)
  assign mixed = x ^ subkey;
  always_comb begin
    y_enc = sbox_words(rnd[2:0], 1'b0, mixed);
    if (rnd != 6'd31) y_enc = lin_fwd(y_enc);
  end

  // decrypt: inverse linear step (skipped right after final mix), inverse S-box, mix
  always_comb begin
    lin = (rnd == 6'd31) ? x : lin_inv(x);
    y_dec = sbox_words(rnd[2:0], 1'b1, lin) ^ subkey;
  end

  // plain key mix, used for the final whitening
  assign y_mix = decrypt ? mixed : mixed;

endmodule
